@@ sv/rotary_encoder_accel_counter_assert.svh @@
// Assertion macros used by the encoder counter back end.
`ifndef ROTARY_ENCODER_ACCEL_COUNTER_ASSERT_SVH
`define ROTARY_ENCODER_ACCEL_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define REC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define REC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rec_pkg.sv @@
package rec_pkg;

   // Number of encoders with live state; the index field is 2 bits wide
   localparam int NUM_ENCODERS = 4;
   localparam int ENC_SEL_W    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

   // Stream widths
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 48;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // Front-to-back queue
   localparam int QUEUE_DEPTH  = 2;

   // Config reset values
   localparam logic [15:0] RST_VERY_FAST_WIN = 16'd10;
   localparam logic [15:0] RST_FAST_WIN      = 16'd50;
   localparam logic [15:0] RST_MEDIUM_WIN    = 16'd150;
   localparam logic [7:0]  RST_GAIN_VHIGH    = 8'd8;
   localparam logic [7:0]  RST_GAIN_HIGH     = 8'd4;
   localparam logic [7:0]  RST_GAIN_MEDIUM   = 8'd2;
   localparam logic [7:0]  RST_GAIN_LOW      = 8'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VERY_FAST_WIN = 3'd0,
      CSR_FAST_WIN      = 3'd1,
      CSR_MEDIUM_WIN    = 3'd2,
      CSR_GAIN_VHIGH    = 3'd3,
      CSR_GAIN_HIGH     = 3'd4,
      CSR_GAIN_MEDIUM   = 3'd5,
      CSR_GAIN_LOW      = 3'd6
   } csr_index_type;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_PRESET = 1'b1
   } action_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      action_type         action;
      logic               idx_ok;
      logic [1:0]         encoder_index;
      logic [1:0]         pin_pair;
      logic [31:0]        time_ms;
      logic signed [31:0] preset_value;
   } item_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic [15:0] very_fast_win;
      logic [15:0] fast_win;
      logic [15:0] medium_win;
      logic [7:0]  gain_vhigh;
      logic [7:0]  gain_high;
      logic [7:0]  gain_medium;
      logic [7:0]  gain_low;
   } cfg_type;

   // Result; out_index sits in the low bits
   typedef struct packed {
      logic signed [8:0]  applied_step;
      logic signed [31:0] count_value;
      logic [1:0]         out_index;
   } rsp_type;

   // Transition table: 2 -> 3 steps up, 1 -> 3 steps down, all else holds
   function automatic logic signed [1:0] step_dir(input logic [1:0] prev,
                                                  input logic [1:0] reading);
      logic signed [1:0] dir;
      dir = 2'sd0;
      if (reading == 2'b11) begin
         if (prev == 2'b10) begin
            dir = 2'sd1;
         end else if (prev == 2'b01) begin
            dir = -2'sd1;
         end
      end
      return dir;
   endfunction

endpackage

@@ sv/rec_front.sv @@
module rec_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // encoder_index[1:0], pin_pair[3:2], time_ms[35:4], preset_value[67:36], zero pad
   input  logic [rec_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action[0]
   input  logic [0:0]                         req_tuser,
   input  logic                               pop,
   output rec_pkg::q_head_type                head
);

   rec_pkg::item_type item;
   rec_pkg::item_type slot_ff [rec_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;

   // Unpack and classify the incoming item
   always_comb begin
      item.action        = rec_pkg::action_type'(req_tuser[0]);
      item.encoder_index = req_tdata[1:0];
      item.pin_pair      = req_tdata[3:2];
      item.time_ms       = req_tdata[35:4];
      item.preset_value  = req_tdata[67:36];
      item.idx_ok        = (int'(req_tdata[1:0]) < rec_pkg::NUM_ENCODERS);
   end

   assign req_tready = (fill_ff != 2'(rec_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

@@ sv/rec_back.sv @@
`include "rotary_encoder_accel_counter_assert.svh"

module rec_back (
   input  logic                               clock,
   input  logic                               reset,
   input  rec_pkg::cfg_type                   cfg,
   input  rec_pkg::q_head_type                head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_index[1:0], count_value[33:2], applied_step[42:34], zero pad
   output logic [rec_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic [31:0]                    count_ff [rec_pkg::NUM_ENCODERS];
   logic [1:0]                     prev_ff  [rec_pkg::NUM_ENCODERS];
   logic [31:0]                    last_ff  [rec_pkg::NUM_ENCODERS];
   logic [rec_pkg::ENC_SEL_W-1:0]  sel;
   logic signed [1:0]              dir;
   logic [31:0]                    interval;
   logic [7:0]                     gain;
   logic signed [8:0]              step;
   logic [31:0]                    count_new;
   logic                           is_sample;
   logic                           do_step;
   rec_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Take the head when the result register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || rsp_tready);

   // Step, interval and gain for the head item
   always_comb begin
      sel       = rec_pkg::ENC_SEL_W'(head.item.encoder_index);
      is_sample = (head.item.action == rec_pkg::ACT_SAMPLE);
      dir       = rec_pkg::step_dir(prev_ff[sel], head.item.pin_pair);
      interval  = head.item.time_ms - last_ff[sel];
      if (interval <= {16'd0, cfg.very_fast_win}) begin
         gain = cfg.gain_vhigh;
      end else if (interval <= {16'd0, cfg.fast_win}) begin
         gain = cfg.gain_high;
      end else if (interval <= {16'd0, cfg.medium_win}) begin
         gain = cfg.gain_medium;
      end else begin
         gain = cfg.gain_low;
      end
      do_step = is_sample && (dir != 2'sd0) && head.item.idx_ok;
      step    = 9'sd0;
      if (do_step) begin
         step = (dir > 2'sd0) ? $signed({1'b0, gain}) : -$signed({1'b0, gain});
      end
      count_new = count_ff[sel] + 32'(step);
   end

   // Result for the head item
   always_comb begin
      rsp_in.out_index    = head.item.encoder_index;
      rsp_in.applied_step = step;
      if (!head.item.idx_ok) begin
         rsp_in.count_value = 32'sd0;
      end else if (!is_sample) begin
         rsp_in.count_value = head.item.preset_value;
      end else begin
         rsp_in.count_value = $signed(count_new);
      end
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);
   end

   // Per-encoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rec_pkg::NUM_ENCODERS; k++) begin
            count_ff[k] <= 32'd0;
            prev_ff[k]  <= 2'd0;
            last_ff[k]  <= 32'd0;
         end
      end else if (pop && head.item.idx_ok) begin
         if (!is_sample) begin
            count_ff[sel] <= head.item.preset_value;
         end else begin
            prev_ff[sel] <= head.item.pin_pair;
            if (do_step) begin
               count_ff[sel] <= count_new;
               last_ff[sel]  <= head.item.time_ms;
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   `REC_ASSERT_IMP(a_no_pop_stalled, clock, reset, rsp_valid_ff && !rsp_tready, !pop, "item taken while result stalled")
   `REC_ASSERT_NXT(a_index_follows, clock, reset, pop, rsp_ff.out_index == $past(head.item.encoder_index), "result index differs from item")
   `REC_ASSERT_NXT(a_preset_no_step, clock, reset, pop && head.item.action == rec_pkg::ACT_PRESET, rsp_ff.applied_step == 9'sd0, "preset reported a step")
   `REC_ASSERT_NXT(a_bad_index_zero, clock, reset, pop && !head.item.idx_ok, rsp_ff.count_value == 32'sd0, "unknown encoder reported a count")

endmodule

@@ sv/rotary_encoder_accel_counter.sv @@
// Channel   Direction  Payload
// req_      in         tdata: encoder_index, pin_pair, time_ms, preset_value; tuser: action
// rsp_      out        tdata: out_index, count_value, applied_step
// csr_      in         write enable, register index, write data
//
// One item per cycle sustained while results are taken. Each accepted item
// goes through a queue slot and then the result register. The rate is set
// by the read-modify-write of the per-encoder count, reading and step-time
// registers in the back end.
// A two-item queue decouples the input from the result register, so input
// stalls only once the queue is full behind a stalled result.
// Synchronous reset clears counts, readings, step times and config to defaults.
module rotary_encoder_accel_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // encoder_index[1:0], pin_pair[3:2], time_ms[35:4], preset_value[67:36], zero pad
   input  logic [rec_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action[0]
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_index[1:0], count_value[33:2], applied_step[42:34], zero pad
   output logic [rec_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [rec_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rec_pkg::cfg_type     cfg_ff, cfg_in;
   rec_pkg::q_head_type  head;
   logic                 pop;

   // Config register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (rec_pkg::csr_index_type'(csr_index))
            rec_pkg::CSR_VERY_FAST_WIN: cfg_in.very_fast_win = csr_wdata;
            rec_pkg::CSR_FAST_WIN:      cfg_in.fast_win      = csr_wdata;
            rec_pkg::CSR_MEDIUM_WIN:    cfg_in.medium_win    = csr_wdata;
            rec_pkg::CSR_GAIN_VHIGH:    cfg_in.gain_vhigh    = csr_wdata[7:0];
            rec_pkg::CSR_GAIN_HIGH:     cfg_in.gain_high     = csr_wdata[7:0];
            rec_pkg::CSR_GAIN_MEDIUM:   cfg_in.gain_medium   = csr_wdata[7:0];
            rec_pkg::CSR_GAIN_LOW:      cfg_in.gain_low      = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.very_fast_win <= rec_pkg::RST_VERY_FAST_WIN;
         cfg_ff.fast_win      <= rec_pkg::RST_FAST_WIN;
         cfg_ff.medium_win    <= rec_pkg::RST_MEDIUM_WIN;
         cfg_ff.gain_vhigh    <= rec_pkg::RST_GAIN_VHIGH;
         cfg_ff.gain_high     <= rec_pkg::RST_GAIN_HIGH;
         cfg_ff.gain_medium   <= rec_pkg::RST_GAIN_MEDIUM;
         cfg_ff.gain_low      <= rec_pkg::RST_GAIN_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (pop),
      .head       (head)
   );

   rec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   // Pin readings, A in bit 1, B in bit 0
   localparam logic [1:0] PINS_NONE   = 2'b00;
   localparam logic [1:0] PINS_B_ONLY = 2'b01;
   localparam logic [1:0] PINS_A_ONLY = 2'b10;
   localparam logic [1:0] PINS_BOTH   = 2'b11;

   // Register index with no register behind it
   localparam logic [rec_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   localparam int REPORT_LIMIT = 10;

   // Expected counts per encoder and the queue of results still to come
   class encoder_scoreboard;
      rec_pkg::cfg_type  cfg;
      logic [31:0]       count [rec_pkg::NUM_ENCODERS];
      logic [1:0]        reading [rec_pkg::NUM_ENCODERS];
      logic [31:0]       step_time [rec_pkg::NUM_ENCODERS];
      rec_pkg::rsp_type  expected_q [$];
      int unsigned       failures;

      function new();
         cfg.very_fast_win = 16'd10;
         cfg.fast_win      = 16'd50;
         cfg.medium_win    = 16'd150;
         cfg.gain_vhigh    = 8'd8;
         cfg.gain_high     = 8'd4;
         cfg.gain_medium   = 8'd2;
         cfg.gain_low      = 8'd1;
         for (int k = 0; k < rec_pkg::NUM_ENCODERS; k++) begin
            count[k]     = '0;
            reading[k]   = PINS_NONE;
            step_time[k] = '0;
         end
         failures = 0;
      endfunction

      function void write_reg(logic [rec_pkg::CSR_INDEX_W-1:0] idx,
                              logic [rec_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rec_pkg::CSR_VERY_FAST_WIN: cfg.very_fast_win = data;
            rec_pkg::CSR_FAST_WIN:      cfg.fast_win      = data;
            rec_pkg::CSR_MEDIUM_WIN:    cfg.medium_win    = data;
            rec_pkg::CSR_GAIN_VHIGH:    cfg.gain_vhigh    = data[7:0];
            rec_pkg::CSR_GAIN_HIGH:     cfg.gain_high     = data[7:0];
            rec_pkg::CSR_GAIN_MEDIUM:   cfg.gain_medium   = data[7:0];
            rec_pkg::CSR_GAIN_LOW:      cfg.gain_low      = data[7:0];
            default: ;
         endcase
      endfunction

      // Gain from the unsigned interval since the last step
      function logic [7:0] gain_for(logic [31:0] interval);
         if (interval <= {16'd0, cfg.very_fast_win}) return cfg.gain_vhigh;
         if (interval <= {16'd0, cfg.fast_win})      return cfg.gain_high;
         if (interval <= {16'd0, cfg.medium_win})    return cfg.gain_medium;
         return cfg.gain_low;
      endfunction

      function void note_item(rec_pkg::action_type act, logic [1:0] enc, logic [1:0] pins,
                              logic [31:0] now, logic [31:0] preset);
         rec_pkg::rsp_type  want;
         logic signed [8:0] applied;
         logic [7:0]        gain;
         logic [1:0]        prev;
         applied = '0;
         want.count_value = '0;
         if (enc < rec_pkg::NUM_ENCODERS) begin
            if (act == rec_pkg::ACT_PRESET) begin
               count[enc] = preset;
            end else begin
               prev = reading[enc];
               reading[enc] = pins;
               // only a rise into both-high from one pin high moves the count
               if (pins == PINS_BOTH && (prev == PINS_A_ONLY || prev == PINS_B_ONLY)) begin
                  gain = gain_for(now - step_time[enc]);
                  step_time[enc] = now;
                  applied = (prev == PINS_A_ONLY) ? $signed({1'b0, gain})
                                                  : -$signed({1'b0, gain});
                  count[enc] = count[enc] + {{23{applied[8]}}, applied};
               end
            end
            want.count_value = count[enc];
         end
         want.out_index    = enc;
         want.applied_step = applied;
         expected_q.push_back(want);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_result(logic [rec_pkg::RSP_TDATA_W-1:0] data);
         rec_pkg::rsp_type got;
         rec_pkg::rsp_type want;
         got = data[$bits(rec_pkg::rsp_type)-1:0];
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: index %0d count %h step %0d",
                        got.out_index, got.count_value, got.applied_step);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_index !== want.out_index || got.count_value !== want.count_value ||
             got.applied_step !== want.applied_step) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch: expected index %0d count %h step %0d, ",
                         "got index %0d count %h step %0d"},
                        want.out_index, want.count_value, want.applied_step,
                        got.out_index, got.count_value, got.applied_step);
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rec_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [0:0]                      req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [rec_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [rec_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rec_pkg::CSR_DATA_W-1:0]  csr_wdata;

   encoder_scoreboard sb = new();
   bit                no_idle = 1'b0;
   int unsigned       pushed = 0;

   rotary_encoder_accel_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Interval since the last step, biased to the window edges
   function automatic logic [31:0] pick_interval();
      int unsigned r;
      logic [31:0] w;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         case ($urandom_range(0, 2))
            0: w = {16'd0, sb.cfg.very_fast_win};
            1: w = {16'd0, sb.cfg.fast_win};
            default: w = {16'd0, sb.cfg.medium_win};
         endcase
         return w + 32'($urandom_range(0, 2)) - 32'd1;
      end
      if (r < 7) return $urandom_range(0, 400);
      if (r == 7) return '0;
      if (r == 8) return $urandom;
      return $urandom_range(0, 70000);
   endfunction

   // Result side: ready held for a while, then dropped for a gap
   initial begin
      int hold;
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         hold = no_idle ? 1 : $urandom_range(1, 8);
         repeat (hold) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Called at a falling edge; returns at a falling edge
   task automatic push_item(rec_pkg::action_type act, logic [1:0] enc, logic [1:0] pins,
                            logic [31:0] now, logic [31:0] preset);
      int gap;
      req_tdata  <= {4'd0, preset, now, pins, enc};
      req_tuser  <= act;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_item(act, enc, pins, now, preset);
      pushed++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic sample(logic [1:0] enc, logic [1:0] pins, logic [31:0] now);
      push_item(rec_pkg::ACT_SAMPLE, enc, pins, now, $urandom);
   endtask

   task automatic preset(logic [1:0] enc, logic [31:0] value);
      push_item(rec_pkg::ACT_PRESET, enc, 2'($urandom_range(0, 3)), $urandom, value);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [rec_pkg::CSR_INDEX_W-1:0] idx,
                            logic [rec_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(logic [15:0] w_vfast, logic [15:0] w_fast, logic [15:0] w_med,
                              logic [15:0] g_vhigh, logic [15:0] g_high, logic [15:0] g_med,
                              logic [15:0] g_low);
      drain();
      write_csr(rec_pkg::CSR_VERY_FAST_WIN, w_vfast);
      write_csr(rec_pkg::CSR_FAST_WIN, w_fast);
      write_csr(rec_pkg::CSR_MEDIUM_WIN, w_med);
      write_csr(rec_pkg::CSR_GAIN_VHIGH, g_vhigh);
      write_csr(rec_pkg::CSR_GAIN_HIGH, g_high);
      write_csr(rec_pkg::CSR_GAIN_MEDIUM, g_med);
      write_csr(rec_pkg::CSR_GAIN_LOW, g_low);
      write_csr(CSR_UNUSED, 16'($urandom));
   endtask

   // Mostly clean one-pin-then-both pairs, plus presets and noise
   task automatic run_random(int unsigned n);
      int unsigned start;
      int unsigned r;
      logic [1:0]  enc;
      logic [31:0] now;
      start = pushed;
      while (pushed - start < n) begin
         no_idle = (pushed - start < 40);
         r   = $urandom_range(0, 99);
         enc = 2'($urandom_range(0, 3));
         if (r < 70) begin
            sample(enc, $urandom_range(0, 1) ? PINS_A_ONLY : PINS_B_ONLY, $urandom);
            now = sb.step_time[enc] + pick_interval();
            sample(enc, PINS_BOTH, now);
         end else if (r < 80) begin
            case ($urandom_range(0, 3))
               0: preset(enc, 32'h7fff_ffff - $urandom_range(0, 300));
               1: preset(enc, 32'h8000_0000 + $urandom_range(0, 300));
               default: preset(enc, $urandom);
            endcase
         end else begin
            sample(enc, 2'($urandom_range(0, 3)), $urandom);
         end
      end
      no_idle = 1'b0;
   endtask

   // Generous bound on the whole run
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset gains: each window edge and just past the last one
      sample(2'd0, PINS_A_ONLY, 32'd0);
      sample(2'd0, PINS_BOTH, 32'd10);
      sample(2'd0, PINS_B_ONLY, 32'd11);
      sample(2'd0, PINS_BOTH, 32'd60);
      sample(2'd0, PINS_A_ONLY, 32'd61);
      sample(2'd0, PINS_BOTH, 32'd210);
      sample(2'd0, PINS_A_ONLY, 32'd211);
      sample(2'd0, PINS_BOTH, 32'd361);
      // count wrap upward, then an interval across the clock wrap
      preset(2'd1, 32'h7fff_ffff);
      sample(2'd1, PINS_A_ONLY, 32'hffff_fff0);
      sample(2'd1, PINS_BOTH, 32'hffff_ffff);
      sample(2'd1, PINS_B_ONLY, 32'd0);
      sample(2'd1, PINS_BOTH, 32'd5);
      // count wrap downward
      preset(2'd2, 32'h8000_0000);
      sample(2'd2, PINS_B_ONLY, 32'hffff_ffff);
      sample(2'd2, PINS_BOTH, 32'h0000_0200);
      // pairs that do not step: held high, from none, from one pin to the other
      sample(2'd3, PINS_BOTH, 32'd100);
      sample(2'd3, PINS_BOTH, 32'd101);
      sample(2'd3, PINS_NONE, 32'd102);
      sample(2'd3, PINS_BOTH, 32'd103);
      sample(2'd3, PINS_A_ONLY, 32'd104);
      sample(2'd3, PINS_B_ONLY, 32'd105);
      sample(2'd3, PINS_A_ONLY, 32'd106);
      preset(2'd3, 32'd0);
      run_random(300);

      // all windows and gains zero
      load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(220);

      // all at maximum, gain writes carry upper bits that must be dropped
      load_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      run_random(220);

      load_config(16'($urandom_range(0, 30)), 16'($urandom_range(30, 120)),
                  16'($urandom_range(120, 400)),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_random(220);

      // windows out of order
      load_config(16'd200, 16'd100, 16'd50, 16'd255, 16'd3, 16'd128, 16'd17);
      run_random(220);

      load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
      run_random(220);

      drain();
      repeat (10) @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rec_pkg.sv
sv/rec_front.sv
sv/rec_back.sv
sv/rotary_encoder_accel_counter.sv
test/testbench.sv
